// ===== hw/rtl/smeu_pkg.sv =====
// ----------------------------------------------------------------------------
// Stack machine execute unit package
// Shared widths, operation and status codes, and controller/datapath structs.
// ----------------------------------------------------------------------------
package smeu_pkg;

  localparam int unsigned DATA_WIDTH  = 32;
  localparam int unsigned STACK_DEPTH = 512;
  localparam int unsigned PTR_W       = $clog2(STACK_DEPTH);
  localparam int unsigned DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned CNT_W       = $clog2(DATA_WIDTH + 1);
  localparam int unsigned OP_W        = 3;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned VALUE_W     = 32;

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 3'd0,
    OP_POP  = 3'd1,
    OP_ADD  = 3'd2,
    OP_SUB  = 3'd3,
    OP_MUL  = 3'd4,
    OP_DIV  = 3'd5,
    OP_HALT = 3'd6
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_OVER  = 3'd2,
    ST_DIVZ  = 3'd3,
    ST_HALT  = 3'd4
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic    capture;    // latch instruction, clear result
    logic    rd_next;    // read second element instead of top
    logic    load_a;
    logic    load_b;
    logic    push;
    logic    pop;
    logic    calc;       // add / sub / mul into result reg
    logic    div_start;
    logic    div_step;
    logic    write_back;
    logic    set_halt;
    logic    set_res;    // status-only result
    status_e res_status;
    logic    emit;       // move result to output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_e  op;
    logic halted;
    logic full;
    logic empty;
    logic lt2;
    logic b_zero;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

// ===== hw/rtl/smeu_if.sv =====
// ----------------------------------------------------------------------------
// Stack machine execute unit channels
// Valid/ready instruction and result channels.
// ----------------------------------------------------------------------------
interface smeu_in_if;
  logic                 valid;
  logic                 ready;
  logic [2:0]           operation;
  logic signed [31:0]   immediate;

  modport source (output valid, output operation, output immediate, input ready);
  modport sink   (input valid, input operation, input immediate, output ready);
endinterface

interface smeu_out_if;
  logic                 valid;
  logic                 ready;
  logic [2:0]           status;
  logic signed [31:0]   value;
  logic                 value_valid;
  logic [9:0]           depth;
  logic                 halted_flag;

  modport source (output valid, output status, output value, output value_valid,
                  output depth, output halted_flag, input ready);
  modport sink   (input valid, input status, input value, input value_valid,
                  input depth, input halted_flag, output ready);
endinterface

// ===== hw/rtl/smeu_ctrl.sv =====
// ----------------------------------------------------------------------------
// Stack machine execute unit controller
// One-hot sequencer issuing datapath commands per instruction.
// ----------------------------------------------------------------------------
module smeu_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  smeu_pkg::stat_t  stat_i,
  output smeu_pkg::cmd_t   cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DEC  = 7'b0000010,
    S_RDB  = 7'b0000100,
    S_EXEC = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_WB   = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_status = smeu_pkg::ST_OK;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DEC;
        end
      end
      S_DEC: begin
        state_d = S_FIN;
        if (stat_i.halted) begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = smeu_pkg::ST_HALT;
        end else begin
          case (stat_i.op)
            smeu_pkg::OP_HALT: begin
              cmd_o.set_halt   = 1'b1;
              cmd_o.set_res    = 1'b1;
              cmd_o.res_status = smeu_pkg::ST_HALT;
            end
            smeu_pkg::OP_PUSH: begin
              if (stat_i.full) begin
                cmd_o.set_res    = 1'b1;
                cmd_o.res_status = smeu_pkg::ST_OVER;
              end else begin
                cmd_o.push = 1'b1;
              end
            end
            smeu_pkg::OP_POP: begin
              if (stat_i.empty) begin
                cmd_o.set_res    = 1'b1;
                cmd_o.res_status = smeu_pkg::ST_UNDER;
              end else begin
                cmd_o.pop = 1'b1;
              end
            end
            smeu_pkg::OP_ADD, smeu_pkg::OP_SUB,
            smeu_pkg::OP_MUL, smeu_pkg::OP_DIV: begin
              if (stat_i.lt2) begin
                cmd_o.set_res    = 1'b1;
                cmd_o.res_status = smeu_pkg::ST_UNDER;
              end else begin
                cmd_o.load_a  = 1'b1;
                cmd_o.rd_next = 1'b1;
                state_d       = S_RDB;
              end
            end
            default: ; // unused opcode: no effect, status ok
          endcase
        end
      end
      S_RDB: begin
        cmd_o.load_b = 1'b1;
        state_d      = S_EXEC;
      end
      S_EXEC: begin
        if (stat_i.op == smeu_pkg::OP_DIV) begin
          if (stat_i.b_zero) begin
            cmd_o.set_res    = 1'b1;
            cmd_o.res_status = smeu_pkg::ST_DIVZ;
            state_d          = S_FIN;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = S_DIV;
          end
        end else begin
          cmd_o.calc = 1'b1;
          state_d    = S_WB;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          state_d = S_WB;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_WB: begin
        cmd_o.write_back = 1'b1;
        state_d          = S_FIN;
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

// ===== hw/rtl/smeu_dpath.sv =====
// ----------------------------------------------------------------------------
// Stack machine execute unit datapath
// Stack memory, operand and result registers, ALU, serial divider, output reg.
// ----------------------------------------------------------------------------
module smeu_dpath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  smeu_pkg::cmd_t        cmd_i,
  output smeu_pkg::stat_t       stat_o,
  input  logic [2:0]            operation_i,
  input  logic signed [31:0]    immediate_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [2:0]            status_o,
  output logic signed [31:0]    value_o,
  output logic                  value_valid_o,
  output logic [9:0]            depth_o,
  output logic                  halted_flag_o
);

  localparam int unsigned DW = smeu_pkg::DATA_WIDTH;

  // stack memory, one write and one registered read per cycle
  smeu_pkg::word_t                 mem_q [smeu_pkg::STACK_DEPTH];
  smeu_pkg::word_t                 rdata_q;
  logic [smeu_pkg::PTR_W-1:0]      rd_addr, wr_addr;
  logic                            mem_we;
  smeu_pkg::word_t                 wr_data;

  logic [smeu_pkg::DEPTH_W-1:0]    depth_q, depth_d;
  logic [smeu_pkg::DEPTH_W-1:0]    depth_m1, depth_m2;
  logic                            halted_q;

  smeu_pkg::op_e                   op_q;
  smeu_pkg::word_t                 imm_q, a_q, b_q, r_q;
  logic [2*DW-1:0]                 prod;

  // divider
  smeu_pkg::word_t                 rem_q, quo_q, dvs_q, quo_fix;
  logic                            neg_q;
  logic [smeu_pkg::CNT_W-1:0]      cnt_q;
  logic [DW:0]                     rem_sh, rem_sub;
  logic                            rem_ge;

  smeu_pkg::word_t                 alu_res;

  // result and output registers
  smeu_pkg::status_e               res_status_q;
  smeu_pkg::word_t                 res_value_q;
  logic                            res_valid_q;
  logic                            out_valid_q;

  assign depth_m1 = depth_q - smeu_pkg::DEPTH_W'(1);
  assign depth_m2 = depth_q - smeu_pkg::DEPTH_W'(2);

  assign rd_addr = cmd_i.rd_next ? depth_m2[smeu_pkg::PTR_W-1:0]
                                 : depth_m1[smeu_pkg::PTR_W-1:0];
  assign mem_we  = cmd_i.push | cmd_i.write_back;
  assign wr_addr = cmd_i.push ? depth_q[smeu_pkg::PTR_W-1:0]
                              : depth_m2[smeu_pkg::PTR_W-1:0];
  assign quo_fix = neg_q ? (~quo_q + smeu_pkg::word_t'(1)) : quo_q;
  assign alu_res = (op_q == smeu_pkg::OP_DIV) ? quo_fix : r_q;
  assign wr_data = cmd_i.push ? imm_q : alu_res;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_comb begin
    depth_d = depth_q;
    if (cmd_i.push) begin
      depth_d = depth_q + smeu_pkg::DEPTH_W'(1);
    end else if (cmd_i.pop || cmd_i.write_back) begin
      depth_d = depth_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= '0;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      depth_q <= depth_d;
      if (cmd_i.set_halt) begin
        halted_q <= 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // magnitude-based restoring division, one quotient bit per step
  assign rem_sh  = {rem_q, quo_q[DW-1]};
  assign rem_ge  = (rem_sh >= {1'b0, dvs_q});
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign prod    = a_q * b_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q         <= smeu_pkg::op_e'(operation_i);
      imm_q        <= smeu_pkg::word_t'(immediate_i);
      res_status_q <= smeu_pkg::ST_OK;
      res_value_q  <= '0;
      res_valid_q  <= 1'b0;
    end
    if (cmd_i.load_a) a_q <= rdata_q;
    if (cmd_i.load_b) b_q <= rdata_q;
    if (cmd_i.calc) begin
      case (op_q)
        smeu_pkg::OP_ADD: r_q <= a_q + b_q;
        smeu_pkg::OP_SUB: r_q <= a_q - b_q;
        default:          r_q <= prod[DW-1:0];
      endcase
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= a_q[DW-1] ? (~a_q + smeu_pkg::word_t'(1)) : a_q;
      dvs_q <= b_q[DW-1] ? (~b_q + smeu_pkg::word_t'(1)) : b_q;
      neg_q <= a_q[DW-1] ^ b_q[DW-1];
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      quo_q <= {quo_q[DW-2:0], rem_ge};
      cnt_q <= cnt_q + smeu_pkg::CNT_W'(1);
    end
    if (cmd_i.set_res) begin
      res_status_q <= cmd_i.res_status;
    end
    if (cmd_i.pop) begin
      res_value_q <= rdata_q;
      res_valid_q <= 1'b1;
    end
    if (cmd_i.write_back) begin
      res_value_q <= alu_res;
      res_valid_q <= 1'b1;
    end
    if (cmd_i.emit) begin
      status_o      <= res_status_q;
      value_o       <= res_value_q[smeu_pkg::VALUE_W-1:0];
      value_valid_o <= res_valid_q;
      depth_o       <= depth_q;
      halted_flag_o <= halted_q;
    end
  end

  assign out_valid_o = out_valid_q;

  assign stat_o.op       = op_q;
  assign stat_o.halted   = halted_q;
  assign stat_o.full     = (depth_q == smeu_pkg::DEPTH_W'(smeu_pkg::STACK_DEPTH));
  assign stat_o.empty    = (depth_q == '0);
  assign stat_o.lt2      = (depth_q < smeu_pkg::DEPTH_W'(2));
  assign stat_o.b_zero   = (b_q == '0);
  assign stat_o.div_done = (cnt_q == smeu_pkg::CNT_W'(DW));
  assign stat_o.out_free = ~out_valid_q | out_ready_i;

endmodule

// ===== hw/rtl/stack_machine_execute_unit_top.sv =====
// ----------------------------------------------------------------------------
// Stack machine execute unit
// Zero-address stack machine: push, pop, add, sub, mul, div, halt.
// ----------------------------------------------------------------------------
// Takes one decoded instruction per beat on in_i and returns exactly one
// result beat on out_o. Items are handled one at a time. From acceptance to
// the load of the result register: push, pop, halt, the unused code,
// overflow and underflow are settled in decode; divide by zero also reads
// the second operand and tests it; add, sub and mul read both operands
// through the single read port of the 512-word stack RAM, compute in the ALU
// and write back; divide runs the restoring divider, which retires one
// quotient bit per cycle (32 steps), and then writes back. The sequencer
// waits in its finish state until the output register is free, moves the
// result there and only then returns to idle to accept again. A finished
// result sits in an output register, so a new instruction is taken while the
// previous result waits for out_o.ready. Binary operations use the top
// element as the first operand; errors leave the stack untouched, and after
// halt every instruction reports halted until reset. Stack contents are not
// cleared at reset, only the depth is.
// ----------------------------------------------------------------------------
module stack_machine_execute_unit_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  smeu_in_if.sink    in_i,
  smeu_out_if.source out_o
);

  // command/status bus between sequencer and datapath
  smeu_pkg::cmd_t  cmd;
  smeu_pkg::stat_t stat;

  // sequencer: owns the in_i handshake, one instruction in flight
  smeu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: stack RAM, operands, ALU, divider and output beat register
  smeu_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .operation_i   (in_i.operation),
    .immediate_i   (in_i.immediate),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .status_o      (out_o.status),
    .value_o       (out_o.value),
    .value_valid_o (out_o.value_valid),
    .depth_o       (out_o.depth),
    .halted_flag_o (out_o.halted_flag)
  );

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Stack machine execute unit testbench
// Drives instruction beats from a queue, predicts each result in the bench
// and compares every result beat against it, under varying idle and stall.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import smeu_pkg::*;

  // Operation code with no meaning: the block must take it and report ok.
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  // Longest run of cycles with no beat on either side before we give up.
  // The long sink hold-off and a divide both stay well inside this limit.
  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned HOLD_OFF_LEN   = 300;
  localparam int unsigned SETTLE_CYCLES  = 60;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [31:0]     imm;
  } instr_t;

  typedef struct packed {
    status_e            status;
    logic [31:0]        value;
    logic               value_valid;
    logic [DEPTH_W-1:0] depth;
    logic               halted_flag;
  } smeu_result_t;

  logic clk_i;
  logic rst_ni;

  smeu_in_if  in_if ();
  smeu_out_if out_if ();

  stack_machine_execute_unit_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Instructions waiting for the driver, and results still owed by the block.
  instr_t       pending_instrs[$];
  smeu_result_t expected_results[$];

  // Bench copy of the machine state, advanced on every accepted beat.
  word_t        stack_mem[STACK_DEPTH];
  int unsigned  stack_level;
  logic         machine_halted;

  int unsigned  sender_idle_pct;
  int unsigned  sink_stall_pct;
  logic         instr_accepted;
  logic         start_hold_off;
  int unsigned  hold_off_cnt;
  int unsigned  quiet_cycles;
  int unsigned  err_count;
  smeu_result_t want;

  // --------------------------------------------------------------------------
  // Clock and reset. Reset is released on a falling edge, well clear of the
  // rising edge that the block samples on.
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // --------------------------------------------------------------------------
  // Predictor. Executes one instruction on the bench copy of the stack and
  // returns the result beat the block should give for it. Errors leave the
  // stack as it was; once halted nothing changes until reset.
  // --------------------------------------------------------------------------
  function automatic smeu_result_t execute_instr(logic [OP_W-1:0] op, logic [31:0] imm);
    smeu_result_t res;
    word_t        opa;
    word_t        opb;
    word_t        mag_a;
    word_t        mag_b;
    word_t        quot;
    word_t        r;
    logic         div_zero;
    res.status      = ST_OK;
    res.value       = '0;
    res.value_valid = 1'b0;
    if (machine_halted) begin
      res.status = ST_HALT;
    end else begin
      case (op)
        OP_HALT: begin
          machine_halted = 1'b1;
          res.status     = ST_HALT;
        end
        OP_PUSH: begin
          if (stack_level >= STACK_DEPTH) begin
            res.status = ST_OVER;
          end else begin
            stack_mem[stack_level] = imm;
            stack_level++;
          end
        end
        OP_POP: begin
          if (stack_level == 0) begin
            res.status = ST_UNDER;
          end else begin
            stack_level--;
            res.value       = stack_mem[stack_level];
            res.value_valid = 1'b1;
          end
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
          if (stack_level < 2) begin
            res.status = ST_UNDER;
          end else begin
            // top of stack is the first operand
            opa      = stack_mem[stack_level - 1];
            opb      = stack_mem[stack_level - 2];
            div_zero = 1'b0;
            r        = '0;
            case (op)
              OP_ADD:  r = opa + opb;
              OP_SUB:  r = opa - opb;
              OP_MUL:  r = opa * opb;
              default: begin
                if (opb == '0) begin
                  div_zero = 1'b1;
                end else begin
                  // unsigned magnitudes, so min / -1 simply wraps back to min
                  mag_a = opa[DATA_WIDTH-1] ? -opa : opa;
                  mag_b = opb[DATA_WIDTH-1] ? -opb : opb;
                  quot  = mag_a / mag_b;
                  r     = (opa[DATA_WIDTH-1] ^ opb[DATA_WIDTH-1]) ? -quot : quot;
                end
              end
            endcase
            if (div_zero) begin
              res.status = ST_DIVZ;
            end else begin
              stack_level--;
              stack_mem[stack_level - 1] = r;
              res.value       = r;
              res.value_valid = 1'b1;
            end
          end
        end
        default: ;  // unused code: no effect, status ok
      endcase
    end
    res.depth       = DEPTH_W'(stack_level);
    res.halted_flag = machine_halted;
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      err_count++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Instruction driver: changes its outputs on the falling edge. A new beat is
  // offered only once the current one has gone, so valid is never dropped
  // while a beat is on offer. Payload carries noise while idle.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && (!in_if.valid || instr_accepted)) begin
      if (pending_instrs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_if.valid     <= 1'b1;
        in_if.operation <= pending_instrs[0].op;
        in_if.immediate <= pending_instrs[0].imm;
        void'(pending_instrs.pop_front());
      end else begin
        in_if.valid     <= 1'b0;
        in_if.operation <= OP_W'($urandom);
        in_if.immediate <= $urandom;
      end
    end
  end

  // Accepted instruction beats go straight into the predictor.
  always @(posedge clk_i) begin
    instr_accepted <= rst_ni && in_if.valid && in_if.ready;
    if (rst_ni && in_if.valid && in_if.ready)
      expected_results.push_back(execute_instr(in_if.operation, in_if.immediate));
  end

  // --------------------------------------------------------------------------
  // Result sink. Random stalls at the current rate, plus one long hold-off on
  // request, counted here, so the block backs up into its input.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (start_hold_off) begin
      start_hold_off <= 1'b0;
      hold_off_cnt   <= HOLD_OFF_LEN;
      out_if.ready   <= 1'b0;
    end else if (hold_off_cnt != 0) begin
      hold_off_cnt <= hold_off_cnt - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= rst_ni && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Result monitor: every beat must match the oldest outstanding prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual status %0d value %0h",
                 $time, out_if.status, out_if.value);
        err_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("status",      32'(want.status),      32'(out_if.status));
        check_field("value",       want.value,            out_if.value);
        check_field("value_valid", 32'(want.value_valid), 32'(out_if.value_valid));
        check_field("depth",       32'(want.depth),       32'(out_if.depth));
        check_field("halted_flag", 32'(want.halted_flag), 32'(out_if.halted_flag));
      end
    end
  end

  // Watchdog: too long without a beat on either channel means a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, no beat for %0d cycles", $time, quiet_cycles);
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_instr(logic [OP_W-1:0] op, logic [31:0] imm);
    instr_t item;
    item.op  = op;
    item.imm = imm;
    pending_instrs.push_back(item);
  endtask

  // Operand values: plenty of extremes, zeros and small numbers so that the
  // divider sees zero divisors, sign mixes and non-trivial quotients.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'h8000_0000;
      5, 6:    return 32'($urandom_range(40)) - 32'd20;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_random_instrs(int unsigned count, int unsigned push_pct,
                                   int unsigned pop_pct);
    int unsigned     pick;
    logic [OP_W-1:0] op;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < push_pct) begin
        op = OP_PUSH;
      end else if (pick < push_pct + pop_pct) begin
        op = OP_POP;
      end else if (pick < 97) begin
        case ($urandom_range(3))
          0:       op = OP_ADD;
          1:       op = OP_SUB;
          2:       op = OP_MUL;
          default: op = OP_DIV;
        endcase
      end else begin
        op = OP_UNUSED;
      end
      queue_instr(op, (op == OP_PUSH) ? pick_operand() : $urandom);
    end
  endtask

  task automatic set_idling(int unsigned idle_pct, int unsigned stall_pct);
    sender_idle_pct = idle_pct;
    sink_stall_pct  = stall_pct;
  endtask

  // Wait until every queued beat is accepted and every result has returned.
  task automatic drain_all();
    while (pending_instrs.size() != 0 || in_if.valid || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned fill_count;
    in_if.valid     = 1'b0;
    in_if.operation = OP_PUSH;
    in_if.immediate = '0;
    out_if.ready    = 1'b0;
    instr_accepted  = 1'b0;
    start_hold_off  = 1'b0;
    hold_off_cnt    = 0;
    quiet_cycles    = 0;
    err_count       = 0;
    stack_level     = 0;
    machine_halted  = 1'b0;
    set_idling(0, 0);

    @(posedge rst_ni);
    @(posedge clk_i);

    // Directed: underflow on empty and on a single entry, wrap-round of add,
    // sub and mul at the extremes, divide by zero, min / -1, truncation of a
    // negative quotient, and the unused opcode.
    queue_instr(OP_POP,    32'h0);
    queue_instr(OP_ADD,    32'h0);
    queue_instr(OP_PUSH,   32'h7FFF_FFFF);
    queue_instr(OP_MUL,    32'h0);
    queue_instr(OP_PUSH,   32'h0000_0001);
    queue_instr(OP_ADD,    32'h0);            // wraps to min
    queue_instr(OP_PUSH,   32'hFFFF_FFFF);
    queue_instr(OP_SUB,    32'hFFFF_FFFF);    // -1 - min
    queue_instr(OP_PUSH,   32'h8000_0000);
    queue_instr(OP_MUL,    32'h0);
    queue_instr(OP_PUSH,   32'h0000_0000);
    queue_instr(OP_DIV,    32'h0);            // zero over min
    queue_instr(OP_PUSH,   32'h0000_0005);
    queue_instr(OP_DIV,    32'h0);            // divisor zero, stack kept
    queue_instr(OP_POP,    32'h0);
    queue_instr(OP_POP,    32'h0);
    queue_instr(OP_PUSH,   32'hFFFF_FFFF);
    queue_instr(OP_PUSH,   32'h8000_0000);
    queue_instr(OP_DIV,    32'h0);            // min / -1 wraps
    queue_instr(OP_POP,    32'h0);
    queue_instr(OP_PUSH,   32'h0000_0002);
    queue_instr(OP_PUSH,   32'hFFFF_FFF9);
    queue_instr(OP_DIV,    32'h0);            // -7 / 2 truncates to -3
    queue_instr(OP_UNUSED, 32'hFFFF_FFFF);
    queue_instr(OP_POP,    32'h0);
    drain_all();

    // Random mix with a gentle upward drift, sender idle much of the time.
    set_idling(54, 0);
    add_random_instrs(120, 55, 15);
    drain_all();

    // Fill to the top and push past it, no idling. The sink holds off for a
    // long stretch at the start so the block backs up.
    set_idling(0, 0);
    @(posedge clk_i);
    start_hold_off = 1'b1;
    fill_count = STACK_DEPTH - stack_level + 3;
    for (int unsigned i = 0; i < fill_count; i++)
      queue_instr(OP_PUSH, pick_operand());
    drain_all();

    // Drain from full, mostly arithmetic, with the sink stalling.
    set_idling(0, 54);
    add_random_instrs(130, 15, 15);
    drain_all();

    set_idling(11, 11);
    add_random_instrs(80, 40, 15);
    drain_all();

    // Halt is final: every later instruction must report halted.
    set_idling(0, 0);
    queue_instr(OP_HALT,   32'h0);
    queue_instr(OP_PUSH,   32'h0000_0042);
    queue_instr(OP_POP,    32'h0);
    queue_instr(OP_ADD,    32'h0);
    queue_instr(OP_UNUSED, 32'h0);
    queue_instr(OP_HALT,   32'h0);
    drain_all();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== stack_machine_execute_unit_top.f =====
hw/rtl/smeu_pkg.sv
hw/rtl/smeu_if.sv
hw/rtl/smeu_ctrl.sv
hw/rtl/smeu_dpath.sv
hw/rtl/stack_machine_execute_unit_top.sv
dv/testbench.sv
